// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and microcode for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Format selector codes
    localparam logic [2:0] FMT_SDEC = 3'd0;
    localparam logic [2:0] FMT_UDEC = 3'd1;
    localparam logic [2:0] FMT_HEXL = 3'd2;
    localparam logic [2:0] FMT_HEXU = 3'd3;
    localparam logic [2:0] FMT_PTR  = 3'd4;

    // Emission codes
    localparam logic [1:0] EM_NONE  = 2'd0;
    localparam logic [1:0] EM_PFX0  = 2'd1;
    localparam logic [1:0] EM_PFX1  = 2'd2;
    localparam logic [1:0] EM_DIGIT = 2'd3;

    // Datapath operation codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_DD    = 2'd1;
    localparam logic [1:0] OP_SKIP  = 2'd2;

    // Jump condition codes
    localparam logic [2:0] C_NEXT   = 3'd0;
    localparam logic [2:0] C_ALWAYS = 3'd1;
    localparam logic [2:0] C_IDLE   = 3'd2;
    localparam logic [2:0] C_HEX    = 3'd3;
    localparam logic [2:0] C_DD     = 3'd4;
    localparam logic [2:0] C_SKIP   = 3'd5;
    localparam logic [2:0] C_DIG    = 3'd6;

    // Program steps
    localparam logic [2:0] S_WAIT   = 3'd0;
    localparam logic [2:0] S_PFX0   = 3'd1;
    localparam logic [2:0] S_PFX1   = 3'd2;
    localparam logic [2:0] S_BRANCH = 3'd3;
    localparam logic [2:0] S_DD     = 3'd4;
    localparam logic [2:0] S_SKIP   = 3'd5;
    localparam logic [2:0] S_DIGIT  = 3'd6;
    localparam logic [2:0] S_LOOP   = 3'd7;

    localparam int unsigned NIBBLES  = 16;
    localparam int unsigned BCD_DIGS = 10;
    localparam logic [4:0]  DD_STEPS_M1 = 5'd31;

    // ASCII codes
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_LA    = 7'h61;
    localparam logic [6:0] CH_UA    = 7'h41;

    typedef struct packed {
        logic       in_rdy;
        logic [1:0] emit;
        logic [1:0] op;
        logic [2:0] cond;
        logic [2:0] target;
    } ctl_t;

    typedef struct packed {
        logic start_ok;
        logic is_hex;
        logic dd_more;
        logic skip_more;
        logic dig_more;
        logic stall;
    } status_t;

    // Control store: one word per step
    function automatic ctl_t ucode(input logic [2:0] pc);
        ctl_t w;
        w = '{in_rdy: 1'b0, emit: EM_NONE, op: OP_NONE, cond: C_NEXT, target: S_WAIT};
        unique case (pc)
            S_WAIT:   begin w.in_rdy = 1'b1; w.cond = C_IDLE; w.target = S_WAIT; end
            S_PFX0:   begin w.emit = EM_PFX0; end
            S_PFX1:   begin w.emit = EM_PFX1; end
            S_BRANCH: begin w.cond = C_HEX; w.target = S_SKIP; end
            S_DD:     begin w.op = OP_DD; w.cond = C_DD; w.target = S_DD; end
            S_SKIP:   begin w.op = OP_SKIP; w.cond = C_SKIP; w.target = S_SKIP; end
            S_DIGIT:  begin w.emit = EM_DIGIT; w.cond = C_DIG; w.target = S_DIGIT; end
            S_LOOP:   begin w.cond = C_ALWAYS; w.target = S_WAIT; end
            default:  begin w.cond = C_ALWAYS; w.target = S_WAIT; end
        endcase
        return w;
    endfunction

    // Digit value to ASCII character
    function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [6:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {3'b000, nib};
        else if (upper)
            c = CH_UA + {3'b000, nib} - 7'd10;
        else
            c = CH_LA + {3'b000, nib} - 7'd10;
        return c;
    endfunction

endpackage

// ===== rtl/itoa_req_if.sv =====
// ----------------------------------------------------------------------------
// itoa_req_if
// Request channel: format selector and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface itoa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ===== rtl/itoa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// itoa_rsp_if
// Response channel: one ASCII character per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface itoa_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic [4:0] char_index;
    logic       last_char;

    modport source (output valid, output ascii_char, output char_index,
                    output last_char, input ready);
    modport sink   (input valid, input ascii_char, input char_index,
                    input last_char, output ready);
endinterface

// ===== rtl/itoa_seq.sv =====
// ----------------------------------------------------------------------------
// itoa_seq
// Step counter, control store lookup and conditional jump logic.
// ----------------------------------------------------------------------------
module itoa_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  itoa_pkg::status_t status,
    output itoa_pkg::ctl_t    ctl
);

    logic [2:0] pc_reg;
    logic [2:0] pc_next;
    logic       take;

    assign ctl = itoa_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            itoa_pkg::C_NEXT:   take = 1'b0;
            itoa_pkg::C_ALWAYS: take = 1'b1;
            itoa_pkg::C_IDLE:   take = !status.start_ok;
            itoa_pkg::C_HEX:    take = status.is_hex;
            itoa_pkg::C_DD:     take = status.dd_more;
            itoa_pkg::C_SKIP:   take = status.skip_more;
            itoa_pkg::C_DIG:    take = status.dig_more;
            default:            take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (status.stall)
            pc_next = pc_reg;
        else if (take)
            pc_next = ctl.target;
        else
            pc_next = pc_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= itoa_pkg::S_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== rtl/itoa_datapath.sv =====
// ----------------------------------------------------------------------------
// itoa_datapath
// Digit register, double-dabble unit, leading-zero skip and output register.
// ----------------------------------------------------------------------------
module itoa_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  itoa_pkg::ctl_t    ctl,
    input  logic              acc,
    input  logic [2:0]        req_type,
    input  logic [63:0]       value,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [6:0]        ascii_char,
    output logic [4:0]        char_index,
    output logic              last_char,
    output itoa_pkg::status_t status
);

    logic        neg_reg,   ptr_reg,   upper_reg,   hex_reg;
    logic [31:0] mag_reg;
    logic [63:0] dig_reg;
    logic [4:0]  ndig_reg;
    logic [4:0]  dd_cnt_reg;
    logic [4:0]  idx_reg;
    logic        out_valid_reg;
    logic [6:0]  char_reg;
    logic [4:0]  index_reg;
    logic        last_reg;

    logic        out_free;
    logic        need;
    logic        emit_do;
    logic [6:0]  emit_char;
    logic        emit_last;
    logic [39:0] bcd_adj;
    logic [31:0] low;
    logic        fmt_ok;

    assign low      = value[31:0];
    assign fmt_ok   = (req_type <= itoa_pkg::FMT_PTR);
    assign out_free = !out_valid_reg || out_ready;

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::BCD_DIGS; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = dig_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        need      = 1'b0;
        emit_char = itoa_pkg::CH_ZERO;
        emit_last = 1'b0;
        case (ctl.emit)
            itoa_pkg::EM_PFX0:
            begin
                need      = neg_reg || ptr_reg;
                emit_char = neg_reg ? itoa_pkg::CH_MINUS : itoa_pkg::CH_ZERO;
            end
            itoa_pkg::EM_PFX1:
            begin
                need      = ptr_reg;
                emit_char = itoa_pkg::CH_X;
            end
            itoa_pkg::EM_DIGIT:
            begin
                need      = 1'b1;
                emit_char = itoa_pkg::digit_char(dig_reg[63:60], upper_reg);
                emit_last = (ndig_reg == 5'd1);
            end
            default:
            begin
                need = 1'b0;
            end
        endcase
    end

    assign emit_do = need && out_free;

    assign status.start_ok  = acc && fmt_ok;
    assign status.is_hex    = hex_reg;
    assign status.dd_more   = (dd_cnt_reg != 5'd0);
    assign status.skip_more = (dig_reg[63:60] == 4'd0) && (ndig_reg > 5'd1);
    assign status.dig_more  = (ndig_reg > 5'd1);
    assign status.stall     = need && !out_free;

    // Working registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            neg_reg    <= (req_type == itoa_pkg::FMT_SDEC) && low[31];
            ptr_reg    <= (req_type == itoa_pkg::FMT_PTR);
            upper_reg  <= (req_type == itoa_pkg::FMT_HEXU);
            hex_reg    <= (req_type == itoa_pkg::FMT_HEXL) ||
                          (req_type == itoa_pkg::FMT_HEXU) ||
                          (req_type == itoa_pkg::FMT_PTR);
            mag_reg    <= ((req_type == itoa_pkg::FMT_SDEC) && low[31]) ? (~low + 32'd1) : low;
            ndig_reg   <= 5'(itoa_pkg::NIBBLES);
            dd_cnt_reg <= itoa_pkg::DD_STEPS_M1;
            idx_reg    <= 5'd0;
            if (req_type == itoa_pkg::FMT_PTR)
                dig_reg <= value;
            else if ((req_type == itoa_pkg::FMT_HEXL) || (req_type == itoa_pkg::FMT_HEXU))
                dig_reg <= {32'd0, low};
            else
                dig_reg <= 64'd0;
        end
        else
        begin
            if (ctl.op == itoa_pkg::OP_DD)
            begin
                dig_reg    <= {24'd0, bcd_adj[38:0], mag_reg[31]};
                mag_reg    <= {mag_reg[30:0], 1'b0};
                dd_cnt_reg <= dd_cnt_reg - 5'd1;
            end
            else if ((ctl.op == itoa_pkg::OP_SKIP) && status.skip_more)
            begin
                dig_reg  <= {dig_reg[59:0], 4'd0};
                ndig_reg <= ndig_reg - 5'd1;
            end
            if (emit_do)
            begin
                idx_reg <= idx_reg + 5'd1;
                if (ctl.emit == itoa_pkg::EM_DIGIT)
                begin
                    dig_reg  <= {dig_reg[59:0], 4'd0};
                    ndig_reg <= ndig_reg - 5'd1;
                end
            end
        end
    end

    // Output register: hold the beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_do)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_do)
        begin
            char_reg  <= emit_char;
            index_reg <= idx_reg;
            last_reg  <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign char_index = index_reg;
    assign last_char  = last_reg;

endmodule

// ===== rtl/integer_to_ascii_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one integer as ASCII text, one character per response beat.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a format selector (req_type) and a 64-bit value. Signed and
//   unsigned decimal and both hex cases use the low 32 bits; the pointer
//   format prints all 64 bits behind "0x". Selectors 5 to 7 are accepted and
//   dropped without any response beat.
//   rsp returns the text most significant character first; each beat has the
//   character, its position and a last flag on the final character.
// Timing:
//   One request is in flight at a time; req.ready is high only while the
//   sequencer waits for work. After the accept cycle and three prefix and
//   branch steps, decimal requests run a 32-step double-dabble conversion,
//   then skip leading zero nibbles and emit one character per cycle while
//   the receiver does not stall, and one closing step follows; hex and
//   pointer requests branch straight to the skip. The next request is
//   taken only after the closing step, and later when the receiver stalls.
// Reset and stall:
//   Reset returns the sequencer to its wait step and clears the output beat.
//   While rsp.ready is low the pending beat holds and emitting steps halt.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
    input  logic     clk,
    input  logic     rst_n,
    itoa_req_if.sink   req,
    itoa_rsp_if.source rsp
);

    itoa_pkg::ctl_t    ctl;
    itoa_pkg::status_t status;
    logic              acc;

    // Take a request only in the wait step
    assign req.ready = ctl.in_rdy;
    assign acc       = req.valid && ctl.in_rdy;

    itoa_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    itoa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .acc        (acc),
        .req_type   (req.req_type),
        .value      (req.value),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .ascii_char (rsp.ascii_char),
        .char_index (rsp.char_index),
        .last_char  (rsp.last_char),
        .status     (status)
    );

endmodule

// ===== dv/itoa_text_checker.sv =====
// ----------------------------------------------------------------------------
// itoa_text_checker
// Watches the request and response channels of the formatter. It rebuilds
// the expected text of every accepted request and compares each response
// beat, field by field, with the oldest expected character.
// ----------------------------------------------------------------------------
module itoa_text_checker
(
    input  logic        clk,
    input  logic        rst_n,
    itoa_req_if         req,
    itoa_rsp_if         rsp,
    output int unsigned mismatch_count,
    output int unsigned beats_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] ch;
        logic [4:0] pos;
        logic       last;
    } text_beat_t;

    text_beat_t expected_text [$];

    // Build the characters of one value, most significant first.
    function automatic void format_text(input logic [2:0] sel, input logic [63:0] v);
        logic [6:0]  chars [$];
        logic [6:0]  digits [$];
        logic [63:0] mag;
        logic [63:0] radix;
        logic [3:0]  d;
        logic        upper;
        text_beat_t  b;
        mag   = {32'd0, v[31:0]};
        radix = 64'd16;
        upper = 1'b0;
        case (sel)
            itoa_pkg::FMT_SDEC:
            begin
                radix = 64'd10;
                if (v[31])
                begin
                    chars.push_back(itoa_pkg::CH_MINUS);
                    // the most negative value maps onto itself as a magnitude
                    mag = {32'd0, ~v[31:0] + 32'd1};
                end
            end
            itoa_pkg::FMT_UDEC: radix = 64'd10;
            itoa_pkg::FMT_HEXL: upper = 1'b0;
            itoa_pkg::FMT_HEXU: upper = 1'b1;
            itoa_pkg::FMT_PTR:
            begin
                chars.push_back(itoa_pkg::CH_ZERO);
                chars.push_back(itoa_pkg::CH_X);
                mag = v;
            end
            default: return;
        endcase
        do
        begin
            d = 4'(mag % radix);
            if (d < 4'd10)
                digits.push_front(itoa_pkg::CH_ZERO + 7'(d));
            else
                digits.push_front((upper ? itoa_pkg::CH_UA : itoa_pkg::CH_LA) +
                                  7'(d) - 7'd10);
            mag = mag / radix;
        end
        while (mag != 64'd0);
        foreach (digits[i])
            chars.push_back(digits[i]);
        foreach (chars[i])
        begin
            b.ch   = chars[i];
            b.pos  = 5'(i);
            b.last = (i == chars.size() - 1);
            expected_text.push_back(b);
        end
    endfunction

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] beat error: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : watch
        text_beat_t want;
        if (!rst_n)
        begin
            mismatch_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_text.size() == 0)
                    note_error($sformatf("no character expected, got char 'h%02h pos %0d last %0b",
                                         rsp.ascii_char, rsp.char_index, rsp.last_char));
                else
                begin
                    want = expected_text.pop_front();
                    if (want.ch !== rsp.ascii_char || want.pos !== rsp.char_index ||
                        want.last !== rsp.last_char)
                        note_error($sformatf({"expected char 'h%02h pos %0d last %0b, ",
                                              "got char 'h%02h pos %0d last %0b"},
                                             want.ch, want.pos, want.last,
                                             rsp.ascii_char, rsp.char_index, rsp.last_char));
                end
            end
            if (req.valid && req.ready)
                format_text(req.req_type, req.value);
        end
        beats_pending <= expected_text.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the integer to ASCII formatter with a directed set of values
// (extremes, zeros, the most negative signed value, the longest pointer,
// dropped selectors) and then with random values in bursts, while the
// response side stalls on its own pattern. The checker beside the block
// predicts every character; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 130;
    // The slowest run is bounded by conversion plus 18 beats at the longest
    // stall per value, plus burst gaps; the limit allows many times that.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_CYCLES = 64;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned mismatch_count;
    int unsigned beats_pending;

    // Receiver stall pattern: a longest stall chosen per phase.
    int unsigned stall_max  = 0;
    int unsigned stall_left = 0;
    int unsigned phase_left = 0;

    itoa_req_if req ();
    itoa_rsp_if rsp ();

    integer_to_ascii_formatter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    itoa_text_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Abort a hung run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Hold ready low for a random count of cycles after each ready cycle.
    // Phases with no stall at all keep the response path at full rate.
    always @(posedge clk)
    begin
        if (phase_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_max = 0;
                1:       stall_max = 1;
                2:       stall_max = 3;
                default: stall_max = 6;
            endcase
            phase_left = $urandom_range(20, 120);
        end
        else
            phase_left--;
        if (stall_left == 0)
        begin
            rsp.ready  <= 1'b1;
            stall_left  = $urandom_range(0, stall_max);
        end
        else
        begin
            rsp.ready <= 1'b0;
            stall_left--;
        end
    end

    // Offer one request and wait until it is accepted. Between bursts drop valid for
    // a random gap; a gap of zero merges two bursts.
    task automatic send_item(input logic [2:0] sel, input logic [63:0] v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        req.valid    <= 1'b1;
        req.req_type <= sel;
        req.value    <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every expected character has arrived.
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_pending != 0);
    endtask

    // Pick a value that spreads the digit count and hits sign edges.
    function automatic logic [63:0] pick_value();
        logic [63:0] raw;
        logic [31:0] p;
        raw = {$urandom, $urandom};
        p   = 32'd1;
        case ($urandom_range(0, 6)) inside
            0, 1: return raw;
            2:    return raw >> $urandom_range(0, 63);
            3:    return {raw[63:32], 32'($urandom_range(0, 20))};
            4:    return {raw[63:32], 32'h8000_0000 + 32'($urandom_range(0, 3))};
            5:    return {raw[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
            default:
            begin
                // power of ten or one below it
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return {raw[63:32], p - 32'($urandom_range(0, 1))};
            end
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned formatted;
        int unsigned hold_point;
        logic [2:0]  sel;
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.req_type = itoa_pkg::FMT_SDEC;
        req.value    = '0;
        formatted    = 0;
        hold_point   = $urandom_range(30, 110);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, extremes, the most negative signed value, case of
        // hex letters, the longest pointer and the dropped selectors.
        send_item(itoa_pkg::FMT_SDEC, 64'd0);
        send_item(itoa_pkg::FMT_SDEC, 64'hFFFF_FFFF_8000_0000);
        send_item(itoa_pkg::FMT_SDEC, 64'h0000_0000_7FFF_FFFF);
        send_item(itoa_pkg::FMT_SDEC, 64'h0000_0000_FFFF_FFFF);
        send_item(itoa_pkg::FMT_SDEC, 64'hA5A5_A5A5_0000_007B);
        send_item(itoa_pkg::FMT_UDEC, 64'd0);
        send_item(itoa_pkg::FMT_UDEC, 64'h0000_0000_FFFF_FFFF);
        send_item(itoa_pkg::FMT_UDEC, 64'hFFFF_FFFF_3B9A_CA00);
        send_item(itoa_pkg::FMT_HEXL, 64'd0);
        send_item(itoa_pkg::FMT_HEXL, 64'h0000_0000_DEAD_BEEF);
        send_item(itoa_pkg::FMT_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(itoa_pkg::FMT_HEXU, 64'd0);
        send_item(itoa_pkg::FMT_HEXU, 64'h1234_5678_ABCD_EF01);
        send_item(itoa_pkg::FMT_HEXU, 64'h0000_0000_FFFF_FFFF);
        send_item(itoa_pkg::FMT_PTR,  64'd0);
        send_item(itoa_pkg::FMT_PTR,  64'd1);
        send_item(itoa_pkg::FMT_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
        send_item(itoa_pkg::FMT_PTR,  64'h8000_0000_0000_0000);
        send_item(itoa_pkg::FMT_PTR,  64'h0123_4567_89AB_CDEF);
        send_item(3'd5,               64'hFFFF_FFFF_FFFF_FFFF);
        send_item(3'd6,               64'h0000_0000_0000_0001);
        send_item(3'd7,               64'h8000_0000_0000_0000);
        send_item(itoa_pkg::FMT_SDEC, 64'h0000_0000_8000_0001);
        wait_drained();

        // Random: mostly valid formats, a few dropped selectors that do not
        // count toward the total. Pause once midway until the block drains.
        while (formatted < RANDOM_ITEMS)
        begin
            if (formatted == hold_point)
            begin
                wait_drained();
                hold_point = 0;
            end
            if ($urandom_range(0, 15) == 0)
                sel = 3'($urandom_range(5, 7));
            else
                sel = 3'($urandom_range(0, 4));
            send_item(sel, pick_value());
            if (sel <= itoa_pkg::FMT_PTR)
                formatted++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && beats_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
